[design/swdt_pkg.sv]
// shared types and constants for the sleep/wakeup deadline table
`default_nettype none
package swdt_pkg;

  localparam int DEPTH     = 16;
  localparam int TW        = 48;
  localparam int TID_W     = 8;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int PAY_W     = TID_W + TW;
  localparam int IN_DATA_W = ((PAY_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((PAY_W + 7) / 8) * 8;

  localparam logic MODE_SLEEP = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPEND,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic latch;
    logic append;
    logic scan_step;
    logic scan_finish;
    logic emit_load;
  } cmd_t;

  typedef struct packed {
    logic in_mode;
    logic scan_done;
    logic emit_ready;
    logic emit_last;
  } stat_t;

endpackage
`default_nettype wire

[design/sleep_wakeup_deadline_table.sv]
// top level of the sleep/wakeup deadline table
//
//   channel | direction | tdata                            | tuser             | tlast
//   in_     | slave     | [7:0] thread_id, [55:8] tick_value | mode            | -
//   out_    | master    | [7:0] woken_thread, [55:8] next_wake | [0] woke, [1] status | last
//
// a sleep request goes through accept, table append, result load
// a tick scans the table, one entry per cycle through the single compare unit, then
//   emits one result per cycle from the wake buffer while out_tready is high
// the next request is taken once the last result sits in the output register
// rst_n clears the entry count, the earliest deadline and all handshake state
// out_tready low holds the result register and stalls the result sequence
`default_nettype none
module sleep_wakeup_deadline_table (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [swdt_pkg::IN_DATA_W-1:0]    in_tdata,   // thread_id, tick_value
  input  wire logic                              in_tuser,   // mode
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [swdt_pkg::OUT_DATA_W-1:0]        out_tdata,  // woken_thread, next_wake
  output logic [1:0]                             out_tuser,  // woke, status
  output logic                                   out_tlast
);
  import swdt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  swdt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  swdt_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

[design/swdt_ctrl.sv]
// controller state machine for the sleep/wakeup deadline table
`default_nettype none
module swdt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire swdt_pkg::stat_t stat,
  output swdt_pkg::cmd_t      cmd
);
  import swdt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (stat.in_mode == MODE_TICK) ? ST_SCAN : ST_APPEND;
        end
      end
      ST_APPEND: state_nxt = ST_EMIT;
      ST_SCAN: begin
        if (stat.scan_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.emit_ready && stat.emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.latch = in_tvalid;
      end
      ST_APPEND: cmd.append = 1'b1;
      ST_SCAN: begin
        cmd.scan_step   = !stat.scan_done;
        cmd.scan_finish = stat.scan_done;
      end
      ST_EMIT: cmd.emit_load = stat.emit_ready;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

[design/swdt_datapath.sv]
// entry table, scan counters, wake buffer and result register
`default_nettype none
module swdt_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire swdt_pkg::cmd_t                    cmd,
  output swdt_pkg::stat_t                        stat,
  input  wire logic [swdt_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire logic                              in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [swdt_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic [1:0]                             out_tuser,
  output logic                                   out_tlast
);
  import swdt_pkg::*;

  // table and wake buffer
  logic [TID_W-1:0] tbl_thr_r [DEPTH];
  logic [TW-1:0]    tbl_dl_r  [DEPTH];
  logic [TID_W-1:0] wbuf_r    [DEPTH];

  logic             mode_r;
  logic [TID_W-1:0] tid_r;
  logic [TW-1:0]    t_r;
  logic             reject_r;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] scan_idx_r;
  logic [CNT_W-1:0] keep_r;
  logic [CNT_W-1:0] nwoken_r;
  logic [CNT_W-1:0] emit_idx_r;
  logic [TW-1:0]    earliest_r;

  logic             out_valid_r;
  logic [TID_W-1:0] out_thr_r;
  logic             out_woke_r;
  logic             out_status_r;
  logic [TW-1:0]    out_wake_r;
  logic             out_last_r;

  logic [TID_W-1:0] rd_thr;
  logic [TW-1:0]    rd_dl;
  logic             rd_wake;
  logic             any_woken;
  logic [CNT_W-1:0] n_results;
  logic             is_full;

  assign rd_thr    = tbl_thr_r[scan_idx_r[IDX_W-1:0]];
  assign rd_dl     = tbl_dl_r[scan_idx_r[IDX_W-1:0]];
  assign rd_wake   = t_r >= rd_dl;
  assign any_woken = (mode_r == MODE_TICK) && (nwoken_r != '0);
  assign n_results = any_woken ? nwoken_r : CNT_W'(1);
  assign is_full   = count_r == CNT_W'(DEPTH);

  assign stat.in_mode    = in_tuser;
  assign stat.scan_done  = scan_idx_r == count_r;
  assign stat.emit_ready = !out_valid_r || out_tready;
  assign stat.emit_last  = (emit_idx_r + CNT_W'(1)) == n_results;

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r <= in_tuser;
      tid_r  <= in_tdata[TID_W-1:0];
      t_r    <= in_tdata[PAY_W-1:TID_W];
    end
    if (cmd.append) begin
      reject_r <= is_full;
    end
  end

  // table writes
  always_ff @(posedge clk) begin
    if (cmd.append && !is_full) begin
      tbl_thr_r[count_r[IDX_W-1:0]] <= tid_r;
      tbl_dl_r[count_r[IDX_W-1:0]]  <= t_r;
    end
    if (cmd.scan_step) begin
      if (rd_wake) begin
        wbuf_r[nwoken_r[IDX_W-1:0]] <= rd_thr;
      end else begin
        tbl_thr_r[keep_r[IDX_W-1:0]] <= rd_thr;
        tbl_dl_r[keep_r[IDX_W-1:0]]  <= rd_dl;
      end
    end
  end

  // counters and earliest deadline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      scan_idx_r <= '0;
      keep_r     <= '0;
      nwoken_r   <= '0;
      emit_idx_r <= '0;
      earliest_r <= '1;
    end else begin
      if (cmd.latch) begin
        emit_idx_r <= '0;
        if (in_tuser == MODE_TICK) begin
          scan_idx_r <= '0;
          keep_r     <= '0;
          nwoken_r   <= '0;
          earliest_r <= '1;
        end
      end
      if (cmd.append && !is_full) begin
        count_r <= count_r + CNT_W'(1);
        if (t_r < earliest_r) begin
          earliest_r <= t_r;
        end
      end
      if (cmd.scan_step) begin
        scan_idx_r <= scan_idx_r + CNT_W'(1);
        if (rd_wake) begin
          nwoken_r <= nwoken_r + CNT_W'(1);
        end else begin
          keep_r <= keep_r + CNT_W'(1);
          if (rd_dl < earliest_r) begin
            earliest_r <= rd_dl;
          end
        end
      end
      if (cmd.scan_finish) begin
        count_r <= keep_r;
      end
      if (cmd.emit_load) begin
        emit_idx_r <= emit_idx_r + CNT_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_thr_r    <= any_woken ? wbuf_r[emit_idx_r[IDX_W-1:0]] : '0;
      out_woke_r   <= any_woken;
      out_status_r <= (mode_r == MODE_SLEEP) && reject_r;
      out_wake_r   <= earliest_r;
      out_last_r   <= stat.emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - PAY_W){1'b0}}, out_wake_r, out_thr_r};
  assign out_tuser  = {out_status_r, out_woke_r};
  assign out_tlast  = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above table depth");

  a_scan_split: assert property (@(posedge clk) disable iff (!rst_n)
    (keep_r + nwoken_r) == scan_idx_r)
    else $error("kept plus woken entries differ from scanned entries");

  a_empty_earliest: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (earliest_r == '1))
    else $error("empty table with a pending earliest deadline");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> (scan_idx_r < count_r))
    else $error("scan step past the last entry");

endmodule
`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 100ps
// self-checking testbench for the sleep/wakeup deadline table with a built-in wakeup predictor
module tb_top;
  import swdt_pkg::*;

  localparam logic [TW-1:0] NEVER = '1;

  typedef struct packed {
    logic [TID_W-1:0] thread;
    logic             woke;
    logic             status;
    logic [TW-1:0]    next_wake;
    logic             last;
  } wake_result_t;

  typedef struct packed {
    logic             mode;
    logic [TID_W-1:0] tid;
    logic [TW-1:0]    tval;
    logic             typed;
    wake_result_t     exp_res;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;

  // predictor state: sleeping threads in insertion order
  logic [TID_W-1:0] sleep_thread [DEPTH];
  logic [TW-1:0]    sleep_deadline [DEPTH];
  int               sleep_count;
  logic [TW-1:0]    earliest_wake;

  wake_result_t wakeup_q[$];
  plan_row_t    plan[$];

  int  error_count;
  int  request_count;
  int  refused_count;
  int  woken_count;
  bit  calm;

  sleep_wakeup_deadline_table DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("timeout with %0d results outstanding", wakeup_q.size());
    $display("DONE: errors detected");
    $finish;
  end

  function automatic wake_result_t mk_result(input logic [TID_W-1:0] thread, input logic woke,
                                             input logic status, input logic [TW-1:0] next_wake,
                                             input logic last);
    wake_result_t r;
    r.thread    = thread;
    r.woke      = woke;
    r.status    = status;
    r.next_wake = next_wake;
    r.last      = last;
    return r;
  endfunction

  function automatic void add_row(input logic mode, input logic [TID_W-1:0] tid,
                                  input logic [TW-1:0] tval, input logic typed,
                                  input wake_result_t exp_res);
    plan_row_t row;
    row.mode    = mode;
    row.tid     = tid;
    row.tval    = tval;
    row.typed   = typed;
    row.exp_res = exp_res;
    plan.push_back(row);
  endfunction

  function automatic void predict_wakeups(input logic mode, input logic [TID_W-1:0] tid,
                                          input logic [TW-1:0] tval);
    logic [TID_W-1:0] woken_ids[$];
    int               keep;
    wake_result_t     r;
    if (mode == MODE_SLEEP) begin
      if (sleep_count >= DEPTH) begin
        wakeup_q.push_back(mk_result('0, 1'b0, 1'b1, earliest_wake, 1'b1));
        refused_count++;
      end else begin
        sleep_thread[sleep_count]   = tid;
        sleep_deadline[sleep_count] = tval;
        sleep_count++;
        if (tval < earliest_wake) earliest_wake = tval;
        wakeup_q.push_back(mk_result('0, 1'b0, 1'b0, earliest_wake, 1'b1));
      end
    end else begin
      keep = 0;
      earliest_wake = NEVER;
      for (int i = 0; i < sleep_count; i++) begin
        if (tval >= sleep_deadline[i]) begin
          woken_ids.push_back(sleep_thread[i]);
        end else begin
          sleep_thread[keep]   = sleep_thread[i];
          sleep_deadline[keep] = sleep_deadline[i];
          keep++;
          if (sleep_deadline[i] < earliest_wake) earliest_wake = sleep_deadline[i];
        end
      end
      sleep_count = keep;
      if (woken_ids.size() == 0) begin
        wakeup_q.push_back(mk_result('0, 1'b0, 1'b0, earliest_wake, 1'b1));
      end else begin
        for (int k = 0; k < woken_ids.size(); k++) begin
          r = mk_result(woken_ids[k], 1'b1, 1'b0, earliest_wake, k == woken_ids.size() - 1);
          wakeup_q.push_back(r);
        end
      end
    end
  endfunction

  task automatic send_request(input logic mode, input logic [TID_W-1:0] tid,
                              input logic [TW-1:0] tval, input logic typed,
                              input wake_result_t exp_res);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {tval, tid};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    predict_wakeups(mode, tid, tval);
    if (typed) wakeup_q[wakeup_q.size() - 1] = exp_res;
    request_count++;
  endtask

  // result side: random stall per result, then compare with the oldest expectation
  initial begin
    int           stall;
    wake_result_t got;
    wake_result_t want;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (out_tvalid !== 1'b1) @(posedge clk);
      got = mk_result(out_tdata[TID_W-1:0], out_tuser[0], out_tuser[1],
                      out_tdata[TID_W +: TW], out_tlast);
      if (got.woke) woken_count++;
      if (wakeup_q.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: thread %h woke %b status %b next %h last %b",
                   got.thread, got.woke, got.status, got.next_wake, got.last);
      end else begin
        want = wakeup_q.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= 10) begin
            $display("mismatch: exp thread %h woke %b status %b next %h last %b",
                     want.thread, want.woke, want.status, want.next_wake, want.last);
            $display("          got thread %h woke %b status %b next %h last %b",
                     got.thread, got.woke, got.status, got.next_wake, got.last);
          end
        end
      end
    end
  end

  initial begin
    logic [TW-1:0]    clock_now;
    logic [TW-1:0]    tval;
    int               sent;
    int               burst;
    int               pick;
    int               drain;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = MODE_SLEEP;
    sleep_count   = 0;
    earliest_wake = NEVER;
    error_count   = 0;
    request_count = 0;
    refused_count = 0;
    woken_count   = 0;
    calm          = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, all-ones deadline, table fill and overflow, bulk wakeups
    add_row(MODE_TICK,  8'h00, '0,        1'b1, mk_result(8'h00, 1'b0, 1'b0, NEVER, 1'b1));
    add_row(MODE_SLEEP, 8'hFF, NEVER,     1'b1, mk_result(8'h00, 1'b0, 1'b0, NEVER, 1'b1));
    add_row(MODE_TICK,  8'hFF, NEVER - 1, 1'b1, mk_result(8'h00, 1'b0, 1'b0, NEVER, 1'b1));
    add_row(MODE_TICK,  8'h00, NEVER,     1'b1, mk_result(8'hFF, 1'b1, 1'b0, NEVER, 1'b1));
    add_row(MODE_SLEEP, 8'h00, '0,        1'b1, mk_result(8'h00, 1'b0, 1'b0, '0, 1'b1));
    for (int i = 1; i < DEPTH; i++)
      add_row(MODE_SLEEP, 8'(i * 17), TW'(1000 * ((i * 7) % 16) + i), 1'b0, '0);
    add_row(MODE_SLEEP, 8'hA5, 48'hAAAA_AAAA_AAAA, 1'b1, mk_result(8'h00, 1'b0, 1'b1, '0, 1'b1));
    add_row(MODE_TICK,  8'h5A, 48'd7000,  1'b0, '0);
    add_row(MODE_TICK,  8'h00, NEVER,     1'b0, '0);
    foreach (plan[i])
      send_request(plan[i].mode, plan[i].tid, plan[i].tval, plan[i].typed, plan[i].exp_res);

    // random: bursts of sleeps around a moving clock, then a tick
    sent = 0;
    clock_now = TW'({$urandom, $urandom});
    while (sent < 250) begin
      calm  = (sent >= 120 && sent < 160);
      burst = ($urandom_range(0, 6) == 0) ? 18 : $urandom_range(0, 3);
      for (int j = 0; j < burst; j++) begin
        pick = $urandom_range(0, 9);
        if (pick < 8) tval = clock_now + $urandom_range(1, 300);
        else if (pick == 8) tval = clock_now - $urandom_range(0, 50);
        else tval = TW'({$urandom, $urandom});
        send_request(MODE_SLEEP, 8'($urandom_range(0, 255)), tval, 1'b0, '0);
        sent++;
      end
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        tval = NEVER;
      end else if (pick == 1) begin
        tval = TW'({$urandom, $urandom});
      end else begin
        clock_now = clock_now + $urandom_range(0, 150);
        tval = clock_now;
      end
      send_request(MODE_TICK, 8'($urandom_range(0, 255)), tval, 1'b0, '0);
      sent++;
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    drain = 0;
    while (wakeup_q.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (40) @(posedge clk);
    if (wakeup_q.size() != 0) begin
      $display("%0d expected results never arrived", wakeup_q.size());
      error_count += wakeup_q.size();
    end

    $display("sent %0d requests, %0d sleeps refused on a full table", request_count,
             refused_count);
    $display("checked %0d woken threads, %0d mismatches", woken_count, error_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
